>>> hdl/counting_bloom_filter_assert.svh
// Assertion macros used by the checker file of the filter.
`ifndef COUNTING_BLOOM_FILTER_ASSERT_SVH
`define COUNTING_BLOOM_FILTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("counting_bloom_filter: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CBF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("counting_bloom_filter: next-cycle check failed");

`endif

>>> hdl/cbf_pkg.sv
// Types, constants and codes shared by the counting Bloom filter modules.
package cbf_pkg;

	// Defaults for the top-level parameters.
	localparam int ADDR_BITS_DEF  = 16;
	localparam int MAX_PROBES_DEF = 16;

	// Key layout: sixteen 32-bit slices taken from eight 64-bit words.
	localparam int KEY_WORDS   = 8;
	localparam int SLICES      = 16;
	localparam int SLICE_W     = 32;
	localparam int SLICE_IDX_W = $clog2(SLICES);

	// One store entry holds the membership bit above a 4-bit usage counter.
	localparam int CNT_W   = 4;
	localparam int ENTRY_W = CNT_W + 1;
	localparam logic [CNT_W-1:0] CNT_MAX = 4'hF;

	// Depth of the command and result queues.
	localparam int QUEUE_DEPTH = 2;

	// Configuration port and register reset values.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam logic [4:0] RST_PROBE_COUNT = 5'd4;
	localparam logic [4:0] RST_SIZE_LOG2   = 5'd16;
	localparam logic       RST_COUNTERS_EN = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROBE_COUNT = 2'd0,
		REG_SIZE_LOG2   = 2'd1,
		REG_COUNTERS_EN = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_TEST   = 2'd0,
		OP_ADD    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	// Work classes handed from the front end to the back end.
	typedef enum logic [2:0] {
		CMD_TEST   = 3'd0,
		CMD_ADD    = 3'd1,
		CMD_REMOVE = 3'd2,
		CMD_CLEAR  = 3'd3,
		CMD_SKIP   = 3'd4
	} cmd_kind_t;

	typedef struct packed {
		op_t         operation;
		logic [63:0] key_word0;
		logic [63:0] key_word1;
		logic [63:0] key_word2;
		logic [63:0] key_word3;
		logic [63:0] key_word4;
		logic [63:0] key_word5;
		logic [63:0] key_word6;
		logic [63:0] key_word7;
	} cbf_in_t;

	typedef struct packed {
		logic is_member;
		logic op_done;
	} cbf_out_t;

	typedef struct packed {
		cmd_kind_t                      kind;
		logic                           member;
		logic [4:0]                     probes;
		logic [4:0]                     size_log2;
		logic                           cnt_en;
		logic [SLICES-1:0][SLICE_W-1:0] slices;
	} cbf_cmd_t;

endpackage

>>> hdl/cbf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cbf_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/cbf_fifo.sv
// Small register queue used between the front end, the back end and the result port.
module cbf_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int LVL_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (level_q == LVL_W'(DEPTH));
	assign empty   = (level_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Storage: no reset needed, the level says what is valid.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !do_push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/cbf_front.sv
// Front end: configuration registers and classification of incoming words.
module cbf_front import cbf_pkg::*; #(
	parameter int ADDR_BITS  = ADDR_BITS_DEF,
	parameter int MAX_PROBES = MAX_PROBES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  cbf_in_t               request,
	output cbf_cmd_t              cmd
);

	logic [4:0] probe_count_q;
	logic [4:0] size_log2_q;
	logic       cnt_en_q;
	logic [4:0] probes;
	logic [4:0] size_sat;

	// The user writes registers only while idle; the block does not enforce it, so no back-pressure.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_count_q <= RST_PROBE_COUNT;
			size_log2_q   <= RST_SIZE_LOG2;
			cnt_en_q      <= RST_COUNTERS_EN;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PROBE_COUNT: probe_count_q <= cfg_data[4:0];
				REG_SIZE_LOG2:   size_log2_q   <= cfg_data[4:0];
				REG_COUNTERS_EN: cnt_en_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Saturate the probe count and the table size to what the store supports.
	assign probes   = (probe_count_q > MAX_PROBES) ? 5'(MAX_PROBES) : probe_count_q;
	assign size_sat = (size_log2_q > ADDR_BITS) ? 5'(ADDR_BITS) : size_log2_q;

	// Build the command: slices in probe order and a work class for the back end.
	always_comb begin
		cmd           = '0;
		cmd.probes    = probes;
		cmd.size_log2 = size_sat;
		cmd.cnt_en    = cnt_en_q;
		cmd.slices[0]  = request.key_word0[63:32];
		cmd.slices[1]  = request.key_word0[31:0];
		cmd.slices[2]  = request.key_word1[63:32];
		cmd.slices[3]  = request.key_word1[31:0];
		cmd.slices[4]  = request.key_word2[63:32];
		cmd.slices[5]  = request.key_word2[31:0];
		cmd.slices[6]  = request.key_word3[63:32];
		cmd.slices[7]  = request.key_word3[31:0];
		cmd.slices[8]  = request.key_word4[63:32];
		cmd.slices[9]  = request.key_word4[31:0];
		cmd.slices[10] = request.key_word5[63:32];
		cmd.slices[11] = request.key_word5[31:0];
		cmd.slices[12] = request.key_word6[63:32];
		cmd.slices[13] = request.key_word6[31:0];
		cmd.slices[14] = request.key_word7[63:32];
		cmd.slices[15] = request.key_word7[31:0];
		// With no probes a test is a trivial hit and updates change nothing, nor do removes with counters off.
		case (request.operation)
			OP_TEST: begin
				cmd.kind   = (probes == '0) ? CMD_SKIP : CMD_TEST;
				cmd.member = (probes == '0);
			end
			OP_ADD: begin
				cmd.kind = (probes == '0) ? CMD_SKIP : CMD_ADD;
			end
			OP_REMOVE: begin
				cmd.kind = (probes == '0 || !cnt_en_q) ? CMD_SKIP : CMD_REMOVE;
			end
			OP_CLEAR: begin
				cmd.kind = CMD_CLEAR;
			end
			default: begin
				cmd.kind = CMD_SKIP;
			end
		endcase
	end

endmodule

>>> hdl/cbf_back.sv
// Back end: probe sequencer doing read-modify-write on the bit and counter store.
module cbf_back import cbf_pkg::*; #(
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cbf_cmd_t cmd,
	input  logic     cmd_empty,
	output logic     cmd_pop,
	output cbf_out_t result,
	output logic     result_push,
	input  logic     result_full,
	output logic     init_busy
);

	typedef enum logic [4:0] {
		S_CLEAR  = 5'b00001,
		S_IDLE   = 5'b00010,
		S_READ   = 5'b00100,
		S_MODIFY = 5'b01000,
		S_REPLY  = 5'b10000
	} state_t;

	state_t                 state_q;
	cbf_cmd_t               cmd_q;
	logic [ADDR_BITS-1:0]   mask_q;
	logic [ADDR_BITS-1:0]   mask_d;
	logic [ADDR_BITS-1:0]   addr_q;
	logic [SLICE_IDX_W-1:0] idx_q;
	logic                   member_q;
	logic                   boot_q;

	logic [ADDR_BITS-1:0]   pos;
	logic                   last_probe;
	logic                   last_addr;
	logic                   ram_we;
	logic                   ram_re;
	logic [ENTRY_W-1:0]     ram_wdata;
	logic [ENTRY_W-1:0]     ram_rdata;
	logic                   bit_rd;
	logic [CNT_W-1:0]       cnt_rd;
	logic                   bit_new;
	logic [CNT_W-1:0]       cnt_new;
	logic                   is_update;

	// Position of the current probe within the table in use.
	assign pos        = cmd_q.slices[idx_q][ADDR_BITS-1:0] & mask_q;
	assign last_probe = (({1'b0, idx_q} + 5'd1) == cmd_q.probes);
	assign last_addr  = &addr_q;
	assign is_update  = (cmd_q.kind == CMD_ADD) || (cmd_q.kind == CMD_REMOVE);

	// Mask of the low size_log2 address bits for the command at the queue head.
	always_comb begin
		for (int b = 0; b < ADDR_BITS; b++) begin
			mask_d[b] = (b < cmd.size_log2);
		end
	end

	// New bit and counter for the entry just read.
	assign bit_rd = ram_rdata[CNT_W];
	assign cnt_rd = ram_rdata[CNT_W-1:0];

	always_comb begin
		bit_new = bit_rd;
		cnt_new = cnt_rd;
		case (cmd_q.kind)
			CMD_ADD: begin
				bit_new = 1'b1;
				if (cmd_q.cnt_en && cnt_rd != CNT_MAX) begin
					cnt_new = cnt_rd + 1'b1;
				end
			end
			CMD_REMOVE: begin
				// A saturated counter is stuck; the bit drops once the count is zero.
				if (cnt_rd != '0 && cnt_rd != CNT_MAX) begin
					cnt_new = cnt_rd - 1'b1;
				end
				if (cnt_new == '0) begin
					bit_new = 1'b0;
				end
			end
			default: ;
		endcase
	end

	// Store access and handshakes with both queues.
	assign cmd_pop     = (state_q == S_IDLE) && !cmd_empty;
	assign ram_re      = (state_q == S_READ);
	assign ram_we      = (state_q == S_CLEAR) || ((state_q == S_MODIFY) && is_update);
	assign ram_wdata   = (state_q == S_CLEAR) ? '0 : {bit_new, cnt_new};
	assign result_push = (state_q == S_REPLY) && !result_full;
	assign result      = '{is_member: member_q, op_done: 1'b1};
	assign init_busy   = boot_q;

	cbf_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (1 << ADDR_BITS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (pos),
		.rdata (ram_rdata)
	);

	// Command payload captured when it leaves the queue.
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q  <= cmd;
			mask_q <= mask_d;
		end
	end

	// Sequencer: clearing sweep, probe read, probe update, reply.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			boot_q   <= 1'b1;
			addr_q   <= '0;
			idx_q    <= '0;
			member_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (last_addr) begin
						boot_q   <= 1'b0;
						member_q <= 1'b0;
						state_q  <= boot_q ? S_IDLE : S_REPLY;
					end
				end
				S_IDLE: begin
					if (!cmd_empty) begin
						idx_q    <= '0;
						addr_q   <= '0;
						member_q <= (cmd.kind == CMD_SKIP) ? cmd.member
						                                   : (cmd.kind == CMD_TEST);
						case (cmd.kind)
							CMD_TEST, CMD_ADD, CMD_REMOVE: state_q <= S_READ;
							CMD_CLEAR:                     state_q <= S_CLEAR;
							default:                       state_q <= S_REPLY;
						endcase
					end
				end
				S_READ: begin
					addr_q  <= pos;
					state_q <= S_MODIFY;
				end
				S_MODIFY: begin
					// A test stops at the first clear bit.
					if (cmd_q.kind == CMD_TEST && !bit_rd) begin
						member_q <= 1'b0;
						state_q  <= S_REPLY;
					end else if (last_probe) begin
						state_q <= S_REPLY;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_REPLY: begin
					if (!result_full) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hdl/counting_bloom_filter.sv
// Top level of the counting Bloom filter with 4-bit saturating usage counters.
//
// Requests enter through a queue-style port: a word is taken on a clock edge
// with push high and full low. Results leave the same way: while empty is low
// the oldest result sits on response and is taken on an edge with pop high.
// Registers are written through cfg_valid/cfg_ready with cfg_index/cfg_data;
// the user must do so only while no request is in flight (not enforced).
// A front end classifies each request into a two-deep command queue; a back
// end probes the store, one read-modify-write of a 5-bit entry per probe, and
// places its result in a two-deep result queue.
// Test, add and remove visit a read state and then a modify state for each
// probe, then a reply state; a test returns early at the first clear bit.
// Clear sweeps the store at one entry a cycle.
// The store's single write and read port sets this order and pace.
// After reset the same sweep zeroes the store; full stays high until the
// sweep ends. Configuration writes are taken throughout.
// When the receiver stalls, results collect in the result queue, then the
// back end waits, then the command queue fills and full rises.
module counting_bloom_filter import cbf_pkg::*; #(
	parameter int ADDR_BITS  = ADDR_BITS_DEF,
	parameter int MAX_PROBES = MAX_PROBES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  cbf_in_t               request,
	output logic                  empty,
	input  logic                  pop,
	output cbf_out_t              response,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cbf_cmd_t cmd_in;
	cbf_cmd_t cmd_head;
	cbf_out_t result;
	logic     cmdq_full;
	logic     cmdq_empty;
	logic     cmd_pop;
	logic     result_push;
	logic     resq_full;
	logic     init_busy;
	logic     accept;

	// No request is taken while the store is being cleared after reset.
	assign full   = cmdq_full || init_busy;
	assign accept = push && !full;

	cbf_front #(
		.ADDR_BITS  (ADDR_BITS),
		.MAX_PROBES (MAX_PROBES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.request   (request),
		.cmd       (cmd_in)
	);

	cbf_fifo #(
		.WIDTH ($bits(cbf_cmd_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  (cmd_in),
		.full   (cmdq_full),
		.pop    (cmd_pop),
		.rdata  (cmd_head),
		.empty  (cmdq_empty)
	);

	cbf_back #(
		.ADDR_BITS (ADDR_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_head),
		.cmd_empty   (cmdq_empty),
		.cmd_pop     (cmd_pop),
		.result      (result),
		.result_push (result_push),
		.result_full (resq_full),
		.init_busy   (init_busy)
	);

	cbf_fifo #(
		.WIDTH ($bits(cbf_out_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (result_push),
		.wdata  (result),
		.full   (resq_full),
		.pop    (pop),
		.rdata  (response),
		.empty  (empty)
	);

endmodule

>>> hdl/cbf_checker.sv
// Port-level checks on the counting Bloom filter, bound to the top level.
`include "counting_bloom_filter_assert.svh"

module cbf_checker import cbf_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     push,
	input logic     full,
	input logic     empty,
	input logic     pop,
	input cbf_out_t response
);

	// Requests taken whose result word has not yet been taken.
	logic [3:0] pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 4'(push && !full) - 4'(pop && !empty);
		end
	end

	`CBF_ASSERT_IMPLY(a_done_set, clk, arst_n, !empty, response.op_done)
	`CBF_ASSERT_IMPLY(a_no_stray_word, clk, arst_n, !empty, pending_q != 4'd0)
	`CBF_ASSERT_NEXT(a_held_word, clk, arst_n, !empty && !pop, !empty && $stable(response))

endmodule

bind counting_bloom_filter cbf_checker u_cbf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.push     (push),
	.full     (full),
	.empty    (empty),
	.pop      (pop),
	.response (response)
);
